// ----- src/eaps_pkg.sv -----
package eaps_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int FULL_TURN  = 1 << ANGLE_BITS;
  localparam int HALF_TURN  = FULL_TURN >> 1;

  localparam int CMD_W     = 2;
  localparam int POS_W     = 32;
  localparam int TIME_W    = 32;
  localparam int REV_W     = POS_W - ANGLE_BITS;
  localparam int SPEED_W   = 41;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = ANGLE_BITS;

  // Scale factors: degrees and RPM in Q8, radians in Q24 shifted to Q8
  localparam int K_W             = 47;
  localparam int RAD_EXTRA_SHIFT = 16;
  localparam logic [K_W-1:0] K_DEG = 47'd92160000000;
  localparam logic [K_W-1:0] K_RPM = 47'd15360000000;
  localparam logic [K_W-1:0] K_RAD = 47'd105414357066578;

  localparam int PROD_W = K_W + ANGLE_BITS;
  // Largest scaled numerator is half a turn in degrees: below 2^36
  localparam int NUM_W  = 36;

  localparam int MUL_CNT_W = $clog2(ANGLE_BITS + 1);
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE     = 2'd0,
    CMD_PRESET     = 2'd1,
    CMD_PRESET_REF = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    UNIT_DEG = 2'd0,
    UNIT_RAD = 2'd1,
    UNIT_RPM = 2'd2
  } unit_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_OFFSET = 2'd0,
    REG_REVERSE_DIR  = 2'd1,
    REG_SPEED_UNIT   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic mul_start;
    logic div_start;
    logic load;
  } ctrl_t;

endpackage

// ----- src/eaps_if.sv -----
interface eaps_sample_if;
  import eaps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [ANGLE_BITS-1:0]     angle_raw;
  logic                      read_error;
  logic                      use_new_angle;
  logic [TIME_W-1:0]         timestamp_us;
  logic signed [POS_W-1:0]   preset_value;

  modport source (
    output valid, command, angle_raw, read_error, use_new_angle, timestamp_us, preset_value,
    input  ready
  );
  modport sink (
    input  valid, command, angle_raw, read_error, use_new_angle, timestamp_us, preset_value,
    output ready
  );
endinterface

interface eaps_result_if;
  import eaps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ANGLE_BITS-1:0]     angle_out;
  logic signed [POS_W-1:0]   position_out;
  logic signed [REV_W-1:0]   revolutions;
  logic signed [SPEED_W-1:0] speed;
  logic                      speed_valid;
  logic signed [POS_W-1:0]   old_position;

  modport source (
    output valid, angle_out, position_out, revolutions, speed, speed_valid, old_position,
    input  ready
  );
  modport sink (
    input  valid, angle_out, position_out, revolutions, speed, speed_valid, old_position,
    output ready
  );
endinterface

interface eaps_cfg_if;
  import eaps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/eaps_mul.sv -----
module eaps_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [eaps_pkg::ANGLE_BITS-1:0] mag,
  input  eaps_pkg::unit_t                 unit,
  output logic                            done,
  output logic [eaps_pkg::NUM_W-1:0]      num
);
  import eaps_pkg::*;

  logic [PROD_W-1:0]     acc;
  logic [PROD_W-1:0]     acc_next;
  logic [ANGLE_BITS-1:0] mult;
  logic [K_W-1:0]        k;
  logic                  rad;
  logic [MUL_CNT_W-1:0]  cnt;
  logic                  busy;
  logic [PROD_W-1:0]     scaled;

  // One multiplier bit per cycle, most significant first
  always_comb begin
    acc_next = {acc[PROD_W-2:0], 1'b0};
    if (mult[ANGLE_BITS-1]) begin
      acc_next = acc_next + {{(PROD_W-K_W){1'b0}}, k};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == MUL_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(ANGLE_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MUL_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      mult <= mag;
      rad  <= (unit == UNIT_RAD);
      unique case (unit)
        UNIT_RAD: k <= K_RAD;
        UNIT_RPM: k <= K_RPM;
        default:  k <= K_DEG;
      endcase
    end else if (busy) begin
      acc  <= acc_next;
      mult <= {mult[ANGLE_BITS-2:0], 1'b0};
    end
  end

  always_comb begin
    scaled = rad ? (acc >> (ANGLE_BITS + RAD_EXTRA_SHIFT)) : (acc >> ANGLE_BITS);
    num    = scaled[NUM_W-1:0];
  end

endmodule

// ----- src/eaps_div.sv -----
module eaps_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [eaps_pkg::NUM_W-1:0]  dividend,
  input  logic [eaps_pkg::TIME_W-1:0] divisor,
  output logic                        done,
  output logic [eaps_pkg::NUM_W-1:0]  quotient
);
  import eaps_pkg::*;

  logic [TIME_W-1:0]    rem;
  logic [TIME_W-1:0]    dvs;
  logic [NUM_W-1:0]     qsh;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [TIME_W:0]      trial;
  logic [TIME_W:0]      diff;
  logic                 ge;

  // Restoring division: dividend bits shift out at the top, quotient bits in at the bottom
  always_comb begin
    trial = {rem, qsh[NUM_W-1]};
    ge    = (trial >= {1'b0, dvs});
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      qsh <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      qsh <= {qsh[NUM_W-2:0], ge};
    end
  end

  assign quotient = qsh;

endmodule

// ----- src/encoder_angle_position_speed.sv -----
// Processing: a reading that yields a speed passes the serial multiply and then the
// restoring divide (ST_MUL, ST_DIV, ST_HOLD) before its result word is loaded;
// presets, failed reads and zero time deltas pass only ST_HOLD before the load.
// Flow: one word at a time, taken only in ST_IDLE once the multiply and divide units
// are through with the last; the next word is taken while a result still waits.
// Reset: synchronous; clears configuration, tracking state, FSM and output valid.
module encoder_angle_position_speed (
  input  logic   clk,
  input  logic   rst,
  eaps_sample_if.sink   samples,
  eaps_result_if.source results,
  eaps_cfg_if.sink      cfg
);
  import eaps_pkg::*;

  // Configuration
  logic [ANGLE_BITS-1:0] angle_offset;
  logic                  reverse_direction;
  unit_t                 speed_unit;

  // Tracking state
  logic [ANGLE_BITS-1:0] last_angle;
  logic [ANGLE_BITS-1:0] speed_ref_angle;
  logic [TIME_W-1:0]     last_time;
  logic [ANGLE_BITS-1:0] position_ref_angle;
  logic [POS_W-1:0]      cumulative_position;

  logic [ANGLE_BITS-1:0] last_angle_next;
  logic [ANGLE_BITS-1:0] speed_ref_angle_next;
  logic [TIME_W-1:0]     last_time_next;
  logic [ANGLE_BITS-1:0] position_ref_angle_next;
  logic [POS_W-1:0]      cumulative_position_next;

  // Pending result
  logic [ANGLE_BITS-1:0] pend_angle;
  logic [POS_W-1:0]      pend_pos;
  logic [POS_W-1:0]      pend_old;
  logic                  pend_go;
  logic                  pend_neg;
  logic [TIME_W-1:0]     pend_dt;

  state_t state;
  state_t state_next;
  ctrl_t  ctrl;

  logic                  take;
  logic [ANGLE_BITS-1:0] corr_sum;
  logic [ANGLE_BITS-1:0] corr;
  logic [ANGLE_BITS-1:0] new_angle;
  logic [ANGLE_BITS-1:0] ref_angle;
  logic signed [ANGLE_BITS:0] da;
  logic signed [ANGLE_BITS:0] du;
  logic [ANGLE_BITS:0]   da_abs;
  logic [ANGLE_BITS-1:0] mag;
  logic [TIME_W-1:0]     dt;
  logic                  go;

  logic                  mul_done;
  logic [NUM_W-1:0]      mul_num;
  logic                  div_done;
  logic [NUM_W-1:0]      quotient;

  logic [POS_W-1:0]      pos_inv;
  logic [REV_W-1:0]      rev;
  logic [SPEED_W-1:0]    spd_mag;
  logic [SPEED_W-1:0]    spd;

  // Difference of two angles folded into [-half turn, +half turn]
  function automatic logic signed [ANGLE_BITS:0] wrap_delta(
    input logic [ANGLE_BITS-1:0] a,
    input logic [ANGLE_BITS-1:0] b
  );
    logic signed [ANGLE_BITS+1:0] d;
    d = $signed({2'b00, a}) - $signed({2'b00, b});
    if (d > $signed((ANGLE_BITS+2)'(HALF_TURN))) begin
      d = d - $signed((ANGLE_BITS+2)'(FULL_TURN));
    end else if (d < -$signed((ANGLE_BITS+2)'(HALF_TURN))) begin
      d = d + $signed((ANGLE_BITS+2)'(FULL_TURN));
    end
    return d[ANGLE_BITS:0];
  endfunction

  assign cfg.ready     = 1'b1;
  assign samples.ready = (state == ST_IDLE);
  assign take          = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_offset      <= '0;
      reverse_direction <= 1'b0;
      speed_unit        <= UNIT_DEG;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_ANGLE_OFFSET: angle_offset      <= cfg.data[ANGLE_BITS-1:0];
        REG_REVERSE_DIR:  reverse_direction <= cfg.data[0];
        REG_SPEED_UNIT:   speed_unit        <= unit_t'(cfg.data[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    corr_sum  = samples.angle_raw + angle_offset;
    corr      = reverse_direction ? (ANGLE_BITS'(0) - corr_sum) : corr_sum;
    new_angle = samples.use_new_angle ? corr : last_angle;
    ref_angle = samples.read_error ? last_angle : corr;
    da        = wrap_delta(new_angle, speed_ref_angle);
    du        = wrap_delta(new_angle, position_ref_angle);
    da_abs    = da[ANGLE_BITS] ? (ANGLE_BITS+1)'(-da) : da;
    mag       = da_abs[ANGLE_BITS-1:0];
    dt        = samples.timestamp_us - last_time;

    last_angle_next          = last_angle;
    speed_ref_angle_next     = speed_ref_angle;
    last_time_next           = last_time;
    position_ref_angle_next  = position_ref_angle;
    cumulative_position_next = cumulative_position;
    go                       = 1'b0;

    unique case (samples.command)
      CMD_SAMPLE: begin
        if (!(samples.use_new_angle && samples.read_error)) begin
          last_angle_next          = new_angle;
          speed_ref_angle_next     = new_angle;
          last_time_next           = samples.timestamp_us;
          position_ref_angle_next  = new_angle;
          cumulative_position_next = cumulative_position
                                   + {{(POS_W-ANGLE_BITS-1){du[ANGLE_BITS]}}, du};
          go                       = (dt != '0);
        end
      end
      CMD_PRESET: begin
        cumulative_position_next = $unsigned(samples.preset_value);
      end
      CMD_PRESET_REF: begin
        last_angle_next          = ref_angle;
        position_ref_angle_next  = ref_angle;
        cumulative_position_next = $unsigned(samples.preset_value);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle          <= '0;
      speed_ref_angle     <= '0;
      last_time           <= '0;
      position_ref_angle  <= '0;
      cumulative_position <= '0;
    end else if (take) begin
      last_angle          <= last_angle_next;
      speed_ref_angle     <= speed_ref_angle_next;
      last_time           <= last_time_next;
      position_ref_angle  <= position_ref_angle_next;
      cumulative_position <= cumulative_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_angle <= last_angle_next;
      pend_pos   <= cumulative_position_next;
      pend_old   <= cumulative_position;
      pend_go    <= go;
      pend_neg   <= da[ANGLE_BITS];
      pend_dt    <= dt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          ctrl.mul_start = go;
          state_next     = go ? ST_MUL : ST_HOLD;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          ctrl.div_start = 1'b1;
          state_next     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // Wait for the output register to free up
        if (!results.valid || results.ready) begin
          ctrl.load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  eaps_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.mul_start),
    .mag   (mag),
    .unit  (speed_unit),
    .done  (mul_done),
    .num   (mul_num)
  );

  eaps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (mul_num),
    .divisor  (pend_dt),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    pos_inv = ~pend_pos;
    rev     = pend_pos[POS_W-1] ? (REV_W'(0) - pos_inv[POS_W-1:ANGLE_BITS])
                                : pend_pos[POS_W-1:ANGLE_BITS];
    spd_mag = {{(SPEED_W-NUM_W){1'b0}}, quotient};
    if (!pend_go) begin
      spd = '0;
    end else if (pend_neg) begin
      spd = SPEED_W'(0) - spd_mag;
    end else begin
      spd = spd_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (ctrl.load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      results.angle_out    <= pend_angle;
      results.position_out <= $signed(pend_pos);
      results.revolutions  <= $signed(rev);
      results.speed        <= $signed(spd);
      results.speed_valid  <= pend_go;
      results.old_position <= $signed(pend_old);
    end
  end

endmodule
